// ----- rtl/igpm_pkg.sv -----
// Shared types and constants of the conservative-to-primitive converter.
package igpm_pkg;

    localparam int WORD_W      = 32;
    localparam int GAMMA_W     = 19;
    localparam int GAMMA_FRAC  = 16;
    localparam int KE_QB       = 50;
    localparam int ECLAMP_BITS = 48;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 19'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;
    localparam logic [WORD_W-1:0]  GAS_RESET   = 32'd18808832;

    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_GAS   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RHO_BAD  = 2'd1,
        ST_P_NEG    = 2'd2,
        ST_NO_SOUND = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] mach;
        logic [WORD_W-1:0] temperature;
        logic [WORD_W-1:0] pressure;
        logic [WORD_W-1:0] velocity_y;
        logic [WORD_W-1:0] velocity_x;
        logic [WORD_W-1:0] density_out;
    } res_t;

endpackage

// ----- rtl/igpm_div.sv -----
// Pipelined restoring divider with one quotient bit per stage and overflow detection.
module igpm_div #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int QB = 50,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en_i,
    input  logic          vld_i,
    input  logic [NW-1:0] num_i,
    input  logic [DW-1:0] den_i,
    input  logic [TW-1:0] tag_i,
    output logic          vld_o,
    output logic [QB-1:0] quo_o,
    output logic          ovf_o,
    output logic [TW-1:0] tag_o
);

    localparam int TOP_W = NW - QB;
    localparam int CW    = (TOP_W > DW) ? TOP_W : DW;

    logic [DW-1:0] rem_reg [0:QB];
    logic [QB-1:0] quo_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic [TW-1:0] tag_reg [0:QB];
    logic          vld_reg [0:QB];

    logic [DW-1:0] rem_next [1:QB];
    logic [QB-1:0] quo_next [1:QB];
    logic [QB-1:0] low_next [1:QB];
    logic [DW-1:0] rem0_next;
    logic          ovf0_next;

    always_comb begin
        logic [CW-1:0] top_ext;
        logic [CW-1:0] den_ext;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          qbit;
        top_ext   = CW'(num_i[NW-1:QB]);
        den_ext   = CW'(den_i);
        ovf0_next = (top_ext >= den_ext);
        rem0_next = DW'(top_ext);
        for (int k = 1; k <= QB; k++) begin
            trial       = {rem_reg[k-1], low_reg[k-1][QB-1]};
            diff        = trial - {1'b0, den_reg[k-1]};
            qbit        = (trial >= {1'b0, den_reg[k-1]});
            rem_next[k] = qbit ? diff[DW-1:0] : trial[DW-1:0];
            quo_next[k] = {quo_reg[k-1][QB-2:0], qbit};
            low_next[k] = low_reg[k-1] << 1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en_i) begin
            vld_reg[0] <= vld_i;
            for (int k = 1; k <= QB; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en_i) begin
            rem_reg[0] <= rem0_next;
            quo_reg[0] <= '0;
            low_reg[0] <= num_i[QB-1:0];
            den_reg[0] <= den_i;
            ovf_reg[0] <= ovf0_next;
            tag_reg[0] <= tag_i;
            for (int k = 1; k <= QB; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                low_reg[k] <= low_next[k];
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign vld_o = vld_reg[QB];
    assign quo_o = quo_reg[QB];
    assign ovf_o = ovf_reg[QB];
    assign tag_o = tag_reg[QB];

endmodule

// ----- rtl/igpm_sqrt.sv -----
// Pipelined integer square root, floor, with one root bit per stage.
module igpm_sqrt #(
    parameter int XW = 64,
    parameter int TW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en_i,
    input  logic            vld_i,
    input  logic [XW-1:0]   x_i,
    input  logic [TW-1:0]   tag_i,
    output logic            vld_o,
    output logic [XW/2-1:0] root_o,
    output logic [TW-1:0]   tag_o
);

    localparam int HW = XW / 2;
    localparam int RW = HW + 2;

    logic [RW-1:0] rem_reg  [0:HW];
    logic [HW-1:0] root_reg [0:HW];
    logic [XW-1:0] xs_reg   [0:HW];
    logic [TW-1:0] tag_reg  [0:HW];
    logic          vld_reg  [0:HW];

    logic [RW-1:0] rem_next  [1:HW];
    logic [HW-1:0] root_next [1:HW];
    logic [XW-1:0] xs_next   [1:HW];

    always_comb begin
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic          rbit;
        for (int k = 1; k <= HW; k++) begin
            rem_sh       = {rem_reg[k-1], xs_reg[k-1][XW-1 -: 2]};
            trial        = (RW+2)'({root_reg[k-1], 2'b01});
            rbit         = (rem_sh >= trial);
            rem_next[k]  = rbit ? RW'(rem_sh - trial) : RW'(rem_sh);
            root_next[k] = {root_reg[k-1][HW-2:0], rbit};
            xs_next[k]   = xs_reg[k-1] << 2;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            for (int k = 0; k <= HW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en_i) begin
            vld_reg[0] <= vld_i;
            for (int k = 1; k <= HW; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en_i) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            xs_reg[0]   <= x_i;
            tag_reg[0]  <= tag_i;
            for (int k = 1; k <= HW; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                xs_reg[k]   <= xs_next[k];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    assign vld_o  = vld_reg[HW];
    assign root_o = root_reg[HW];
    assign tag_o  = tag_reg[HW];

endmodule

// ----- rtl/ideal_gas_primitive_mach.sv -----
// Top level: conservative 2D Euler state to density, velocity, pressure, temperature and Mach.
// Throughput is one beat per cycle while the output buffer is not full.
// The divider and square-root pipelines, one result bit per stage, set the depth.
// A two-entry output buffer keeps input beats flowing while a result waits to be taken.
// Reset is synchronous and active low; it empties the pipeline and restores gamma 1.4 and R 287.
module ideal_gas_primitive_mach import igpm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // density, momentum_x, momentum_y, total_energy (32 bits each, from bit 0 up)
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // density_out, velocity_x, velocity_y, pressure, temperature, mach (32 bits each)
    output logic [191:0]  m_tdata,
    // status
    output logic [1:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int VEL_NW = WORD_W + FRAC_BITS;
    localparam int TMP_NW = WORD_W + 2 * FRAC_BITS;
    localparam int SQ_W   = 2 * WORD_W;
    localparam int RT_W   = SQ_W - FRAC_BITS;
    localparam int A2P_W  = RT_W + GAMMA_W;
    localparam int A2_W   = A2P_W - GAMMA_FRAC;
    localparam int MCH_NW = SQ_W + FRAC_BITS;
    localparam int E_W    = KE_QB + 2;
    localparam int EM_W   = ECLAMP_BITS + 1;
    localparam int PR_W   = EM_W + GAMMA_W;
    localparam int TAG_M  = 5 * WORD_W + 2;
    localparam logic [EM_W-1:0] E_CLAMP = {1'b1, {ECLAMP_BITS{1'b0}}};

    logic [GAMMA_W-1:0] gamma_reg;
    logic [WORD_W-1:0]  gas_reg;
    logic               adv;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
            gas_reg   <= GAS_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_GAMMA: gamma_reg <= pwdata[GAMMA_W-1:0];
                REG_GAS:   gas_reg   <= pwdata;
                default:   gas_reg   <= gas_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GAMMA: prdata = 32'(gamma_reg);
            REG_GAS:   prdata = gas_reg;
            default:   prdata = '0;
        endcase
    end

    // Input capture and momentum squares.
    logic              va_reg, vb_reg, vc_reg;
    logic [WORD_W-1:0] rho_a_reg, mx_a_reg, my_a_reg, en_a_reg;
    logic [WORD_W-1:0] rho_b_reg, mx_b_reg, my_b_reg, en_b_reg;
    logic [WORD_W-1:0] rho_c_reg, mx_c_reg, my_c_reg, en_c_reg;
    logic [SQ_W-1:0]   sqx_b_reg, sqy_b_reg, ssum_c_reg;
    logic [WORD_W-1:0] absx_a, absy_a;

    assign absx_a = mx_a_reg[WORD_W-1] ? -mx_a_reg : mx_a_reg;
    assign absy_a = my_a_reg[WORD_W-1] ? -my_a_reg : my_a_reg;

    // Kinetic energy division and pressure stages.
    logic              ke_vld;
    logic [KE_QB-1:0]  ke_quo, ke_sat;
    logic              ke_ovf;
    logic [4*WORD_W-1:0] ke_tag;
    logic [WORD_W-1:0] rho_k, mx_k, my_k, en_k;
    logic [WORD_W:0]   ke_den;
    logic              rho_pos_c;

    assign rho_pos_c = !rho_c_reg[WORD_W-1] && (rho_c_reg != '0);
    assign ke_den    = rho_pos_c ? {rho_c_reg, 1'b0} : (WORD_W+1)'(1);

    igpm_div #(.NW(SQ_W), .DW(WORD_W + 1), .QB(KE_QB), .TW(4 * WORD_W)) u_ke_div (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(vc_reg),
        .num_i(ssum_c_reg), .den_i(ke_den),
        .tag_i({en_c_reg, my_c_reg, mx_c_reg, rho_c_reg}),
        .vld_o(ke_vld), .quo_o(ke_quo), .ovf_o(ke_ovf), .tag_o(ke_tag)
    );

    assign {en_k, my_k, mx_k, rho_k} = ke_tag;
    assign ke_sat = ke_ovf ? '1 : ke_quo;

    logic              vd_reg, ve_reg, vf_reg, vg_reg;
    logic [WORD_W-1:0] rho_d_reg, mx_d_reg, my_d_reg;
    logic [WORD_W-1:0] rho_e_reg, mx_e_reg, my_e_reg;
    logic [WORD_W-1:0] rho_f_reg, mx_f_reg, my_f_reg;
    logic [WORD_W-1:0] rho_g_reg, mx_g_reg, my_g_reg, p_g_reg;
    logic [SQ_W-1:0]   dr_d_reg, dr_e_reg, dr_f_reg, dr_g_reg;
    logic [E_W-1:0]    e_d_reg, e_next, emag_e;
    logic [EM_W-1:0]   emag_e_reg, emag_next;
    logic              neg_e_reg, neg_f_reg, neg_g_reg, neg_next;
    logic [PR_W-1:0]   prod_f_reg;
    logic [WORD_W-1:0] p_next;
    logic              g_pos, g_neg;
    logic [GAMMA_W-1:0] gmag;

    assign e_next = {{(E_W - WORD_W){en_k[WORD_W-1]}}, en_k} - {2'b00, ke_sat};
    assign emag_e = e_d_reg[E_W-1] ? -e_d_reg : e_d_reg;
    assign emag_next = (emag_e > E_W'(E_CLAMP)) ? E_CLAMP : emag_e[EM_W-1:0];
    assign g_pos = (gamma_reg > GAMMA_ONE);
    assign g_neg = (gamma_reg < GAMMA_ONE);
    assign gmag  = g_pos ? (gamma_reg - GAMMA_ONE) : (GAMMA_ONE - gamma_reg);
    assign neg_next = (e_d_reg[E_W-1] && g_pos)
                   || (!e_d_reg[E_W-1] && (e_d_reg != '0) && g_neg);
    assign p_next = (prod_f_reg[PR_W-1:GAMMA_FRAC+WORD_W] != '0) ? '1
                  : prod_f_reg[GAMMA_FRAC+WORD_W-1:GAMMA_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= ke_vld;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rho_a_reg  <= s_tdata[31:0];
            mx_a_reg   <= s_tdata[63:32];
            my_a_reg   <= s_tdata[95:64];
            en_a_reg   <= s_tdata[127:96];
            rho_b_reg  <= rho_a_reg;
            mx_b_reg   <= mx_a_reg;
            my_b_reg   <= my_a_reg;
            en_b_reg   <= en_a_reg;
            sqx_b_reg  <= SQ_W'(absx_a) * SQ_W'(absx_a);
            sqy_b_reg  <= SQ_W'(absy_a) * SQ_W'(absy_a);
            rho_c_reg  <= rho_b_reg;
            mx_c_reg   <= mx_b_reg;
            my_c_reg   <= my_b_reg;
            en_c_reg   <= en_b_reg;
            ssum_c_reg <= sqx_b_reg + sqy_b_reg;
            rho_d_reg  <= rho_k;
            mx_d_reg   <= mx_k;
            my_d_reg   <= my_k;
            e_d_reg    <= e_next;
            dr_d_reg   <= SQ_W'(gas_reg) * SQ_W'(rho_k);
            rho_e_reg  <= rho_d_reg;
            mx_e_reg   <= mx_d_reg;
            my_e_reg   <= my_d_reg;
            emag_e_reg <= emag_next;
            neg_e_reg  <= neg_next;
            dr_e_reg   <= dr_d_reg;
            rho_f_reg  <= rho_e_reg;
            mx_f_reg   <= mx_e_reg;
            my_f_reg   <= my_e_reg;
            prod_f_reg <= PR_W'(emag_e_reg) * PR_W'(gmag);
            neg_f_reg  <= neg_e_reg;
            dr_f_reg   <= dr_e_reg;
            rho_g_reg  <= rho_f_reg;
            mx_g_reg   <= mx_f_reg;
            my_g_reg   <= my_f_reg;
            p_g_reg    <= p_next;
            neg_g_reg  <= neg_f_reg;
            dr_g_reg   <= dr_f_reg;
        end
    end

    // Velocity and temperature divisions run side by side.
    logic              rho_pos_g;
    logic [WORD_W-1:0] vel_den, absx_g, absy_g;
    logic [SQ_W-1:0]   t_den;
    logic              vx_vld, vy_vld, t_vld;
    logic [WORD_W-1:0] vx_quo, vy_quo, t_quo;
    logic              vx_ovf, vy_ovf, t_ovf;
    logic              vx_sgn, vy_sgn;
    logic [2*WORD_W:0] t_tag;
    logic [WORD_W-1:0] rho_t, p_t;
    logic              neg_t;

    assign rho_pos_g = !rho_g_reg[WORD_W-1] && (rho_g_reg != '0);
    assign vel_den   = rho_pos_g ? rho_g_reg : WORD_W'(1);
    assign absx_g    = mx_g_reg[WORD_W-1] ? -mx_g_reg : mx_g_reg;
    assign absy_g    = my_g_reg[WORD_W-1] ? -my_g_reg : my_g_reg;
    assign t_den     = (dr_g_reg == '0) ? SQ_W'(1) : dr_g_reg;

    igpm_div #(.NW(VEL_NW), .DW(WORD_W), .QB(WORD_W), .TW(1)) u_vx_div (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(vg_reg),
        .num_i({absx_g, {FRAC_BITS{1'b0}}}), .den_i(vel_den),
        .tag_i(mx_g_reg[WORD_W-1]),
        .vld_o(vx_vld), .quo_o(vx_quo), .ovf_o(vx_ovf), .tag_o(vx_sgn)
    );

    igpm_div #(.NW(VEL_NW), .DW(WORD_W), .QB(WORD_W), .TW(1)) u_vy_div (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(vg_reg),
        .num_i({absy_g, {FRAC_BITS{1'b0}}}), .den_i(vel_den),
        .tag_i(my_g_reg[WORD_W-1]),
        .vld_o(vy_vld), .quo_o(vy_quo), .ovf_o(vy_ovf), .tag_o(vy_sgn)
    );

    igpm_div #(.NW(TMP_NW), .DW(SQ_W), .QB(WORD_W), .TW(2 * WORD_W + 1)) u_t_div (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(vg_reg),
        .num_i({p_g_reg, {(2 * FRAC_BITS){1'b0}}}), .den_i(t_den),
        .tag_i({neg_g_reg, p_g_reg, rho_g_reg}),
        .vld_o(t_vld), .quo_o(t_quo), .ovf_o(t_ovf), .tag_o(t_tag)
    );

    assign {neg_t, p_t, rho_t} = t_tag;

    function automatic logic [WORD_W-1:0] sat_vel(input logic sgn, input logic ovf,
                                                  input logic [WORD_W-1:0] q);
        logic [WORD_W-1:0] lim;
        lim = {1'b1, {(WORD_W-1){1'b0}}};
        if (sgn) begin
            sat_vel = (ovf || q > lim) ? lim : -q;
        end else begin
            sat_vel = (ovf || q[WORD_W-1]) ? ~lim : q;
        end
    endfunction

    // Sound speed squared and speed squared.
    logic              vh_reg, vi_reg, vj_reg;
    logic [WORD_W-1:0] rho_h_reg, u_h_reg, v_h_reg, p_h_reg, t_h_reg;
    logic [WORD_W-1:0] rho_i_reg, u_i_reg, v_i_reg, p_i_reg, t_i_reg;
    logic [WORD_W-1:0] rho_j_reg, u_j_reg, v_j_reg, p_j_reg, t_j_reg;
    logic              neg_h_reg, neg_i_reg, neg_j_reg;
    logic [SQ_W-1:0]   rt_i_reg, uu_i_reg, vv_i_reg, s_j_reg;
    logic [A2P_W-1:0]  a2p_j_reg;
    logic [WORD_W-1:0] absu_h, absv_h;

    assign absu_h = u_h_reg[WORD_W-1] ? -u_h_reg : u_h_reg;
    assign absv_h = v_h_reg[WORD_W-1] ? -v_h_reg : v_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
        end else if (adv) begin
            vh_reg <= t_vld;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rho_h_reg <= rho_t;
            u_h_reg   <= sat_vel(vx_sgn, vx_ovf, vx_quo);
            v_h_reg   <= sat_vel(vy_sgn, vy_ovf, vy_quo);
            p_h_reg   <= p_t;
            t_h_reg   <= ((gas_reg == '0) || t_ovf) ? '1 : t_quo;
            neg_h_reg <= neg_t;
            rho_i_reg <= rho_h_reg;
            u_i_reg   <= u_h_reg;
            v_i_reg   <= v_h_reg;
            p_i_reg   <= p_h_reg;
            t_i_reg   <= t_h_reg;
            neg_i_reg <= neg_h_reg;
            rt_i_reg  <= SQ_W'(gas_reg) * SQ_W'(t_h_reg);
            uu_i_reg  <= SQ_W'(absu_h) * SQ_W'(absu_h);
            vv_i_reg  <= SQ_W'(absv_h) * SQ_W'(absv_h);
            rho_j_reg <= rho_i_reg;
            u_j_reg   <= u_i_reg;
            v_j_reg   <= v_i_reg;
            p_j_reg   <= p_i_reg;
            t_j_reg   <= t_i_reg;
            neg_j_reg <= neg_i_reg;
            a2p_j_reg <= A2P_W'(rt_i_reg[SQ_W-1:FRAC_BITS]) * A2P_W'(gamma_reg);
            s_j_reg   <= uu_i_reg + vv_i_reg;
        end
    end

    // Mach number: speed squared over sound speed squared, then square root.
    logic [A2_W-1:0]   a2_j, m_den;
    logic              a2_zero_j;
    logic              mq_vld, mq_ovf, sq_vld;
    logic [SQ_W-1:0]   mq_quo;
    logic [TAG_M-1:0]  mq_tag, sq_tag;
    logic [WORD_W-1:0] sq_root;

    assign a2_j      = a2p_j_reg[A2P_W-1:GAMMA_FRAC];
    assign a2_zero_j = (a2_j == '0);
    assign m_den     = a2_zero_j ? A2_W'(1) : a2_j;

    igpm_div #(.NW(MCH_NW), .DW(A2_W), .QB(SQ_W), .TW(TAG_M)) u_m_div (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(vj_reg),
        .num_i({s_j_reg, {FRAC_BITS{1'b0}}}), .den_i(m_den),
        .tag_i({a2_zero_j, neg_j_reg, t_j_reg, p_j_reg, v_j_reg, u_j_reg, rho_j_reg}),
        .vld_o(mq_vld), .quo_o(mq_quo), .ovf_o(mq_ovf), .tag_o(mq_tag)
    );

    igpm_sqrt #(.XW(SQ_W), .TW(TAG_M)) u_sqrt (
        .clk(aclk), .rst_n(aresetn), .en_i(adv), .vld_i(mq_vld),
        .x_i(mq_ovf ? '1 : mq_quo), .tag_i(mq_tag),
        .vld_o(sq_vld), .root_o(sq_root), .tag_o(sq_tag)
    );

    logic [WORD_W-1:0] rho_z, u_z, v_z, p_z, t_z;
    logic              neg_z, a2_zero_z, rho_pos_z;
    res_t              res_next;

    assign {a2_zero_z, neg_z, t_z, p_z, v_z, u_z, rho_z} = sq_tag;
    assign rho_pos_z = !rho_z[WORD_W-1] && (rho_z != '0);

    always_comb begin
        res_next.density_out = rho_z;
        res_next.velocity_x  = u_z;
        res_next.velocity_y  = v_z;
        res_next.pressure    = p_z;
        res_next.temperature = t_z;
        res_next.mach        = a2_zero_z ? '1 : sq_root;
        res_next.status      = a2_zero_z ? ST_NO_SOUND : ST_OK;
        if (!rho_pos_z) begin
            res_next.velocity_x  = '0;
            res_next.velocity_y  = '0;
            res_next.pressure    = '0;
            res_next.temperature = '0;
            res_next.mach        = '0;
            res_next.status      = ST_RHO_BAD;
        end else if (neg_z) begin
            res_next.pressure    = '0;
            res_next.temperature = '0;
            res_next.mach        = '0;
            res_next.status      = ST_P_NEG;
        end
    end

    // Output buffer.
    res_t       fifo_reg [0:FIFO_DEPTH-1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    res_t       res_out;

    assign adv      = (cnt_reg != 2'(FIFO_DEPTH));
    assign s_tready = adv;
    assign push     = sq_vld && adv;
    assign pop      = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign res_out  = fifo_reg[rd_ptr_reg];
    assign m_tdata  = {res_out.mach, res_out.temperature, res_out.pressure,
                       res_out.velocity_y, res_out.velocity_x, res_out.density_out};
    assign m_tuser  = res_out.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_div_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (vx_vld == t_vld) && (vy_vld == t_vld))
        else $error("velocity and temperature dividers out of step");

    a_rho_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_RHO_BAD) |->
        (m_tdata[63:32] == '0 && m_tdata[95:64] == '0 && m_tdata[191:160] == '0))
        else $error("non-positive density beat carries non-zero results");

    a_p_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_P_NEG) |->
        (m_tdata[127:96] == '0 && m_tdata[159:128] == '0 && m_tdata[191:160] == '0))
        else $error("negative pressure beat carries non-zero results");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(FIFO_DEPTH)) |-> !push)
        else $error("output buffer written while full");
`endif

endmodule

// ----- tb/tb_ideal_gas_primitive_mach.sv -----
// Self-checking testbench of the conservative-to-primitive converter with Mach number.
`timescale 1ns / 100ps

module tb_ideal_gas_primitive_mach;
    import igpm_pkg::*;

    localparam int FRAC = 16;
    localparam logic [2:0] ADDR_GAMMA = 3'd4 * REG_GAMMA;
    localparam logic [2:0] ADDR_GAS   = 3'd4 * REG_GAS;
    localparam longint unsigned WMASK = 64'hFFFF_FFFF;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [191:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic [GAMMA_W-1:0] gamma_cfg;
    logic [WORD_W-1:0]  gas_cfg;
    res_t               primitive_q[$];
    int                 mismatch_cnt;
    bit                 gaps_on;
    bit                 stalls_on;
    bit                 hold_req;
    int                 stall_left;

    ideal_gas_primitive_mach u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint unsigned mag(longint signed v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned div_sat(longint unsigned a, int unsigned sh,
                                                longint unsigned d, longint unsigned lim);
        longint unsigned rem;
        longint unsigned q;
        longint unsigned b;
        rem = 0;
        q = 0;
        for (int unsigned i = 0; i < 64 + sh; i++) begin
            b = (i < 64) ? ((a >> (63 - i)) & 64'd1) : 64'd0;
            if (q > (lim >> 1))
                return lim;
            rem = (rem << 1) | b;
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q = q | 64'd1;
            end
        end
        return q > lim ? lim : q;
    endfunction

    function automatic longint unsigned scale_g(longint unsigned x, longint unsigned g);
        return (x >> 16) * g + (((x & 64'hFFFF) * g) >> 16);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint signed sat_s32(longint signed v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic res_t primitive_of(logic [31:0] rho_w, logic [31:0] mx_w,
                                          logic [31:0] my_w, logic [31:0] en_w);
        res_t r;
        longint signed rho;
        longint signed mx;
        longint signed my;
        longint signed en;
        longint signed u;
        longint signed v;
        longint signed e;
        longint signed gm1;
        longint unsigned ke;
        longint unsigned em;
        longint unsigned pm;
        longint unsigned p;
        longint unsigned t;
        longint unsigned a2;
        longint unsigned m;
        rho = longint'(signed'(rho_w));
        mx = longint'(signed'(mx_w));
        my = longint'(signed'(my_w));
        en = longint'(signed'(en_w));
        r = '0;
        r.density_out = rho_w;
        if (rho <= 0) begin
            r.status = ST_RHO_BAD;
            return r;
        end
        u = sat_s32((mx * 65536) / rho);
        v = sat_s32((my * 65536) / rho);
        r.velocity_x = u[31:0];
        r.velocity_y = v[31:0];
        ke = (mag(mx) * mag(mx) + mag(my) * mag(my)) / (2 * longint'(rho));
        e = en - longint'(ke);
        gm1 = longint'(gamma_cfg) - 64'sd65536;
        if ((e < 0 && gm1 > 0) || (e > 0 && gm1 < 0)) begin
            r.status = ST_P_NEG;
            return r;
        end
        em = mag(e);
        if (em > (64'd1 << ECLAMP_BITS))
            em = 64'd1 << ECLAMP_BITS;
        pm = scale_g(em, mag(gm1));
        p = pm > WMASK ? WMASK : pm;
        if (gas_cfg == 0)
            t = WMASK;
        else
            t = div_sat(p, 2 * FRAC, longint'(gas_cfg) * longint'(rho), WMASK);
        a2 = scale_g((longint'(gas_cfg) * t) >> FRAC, longint'(gamma_cfg));
        r.status = ST_OK;
        if (a2 == 0) begin
            r.status = ST_NO_SOUND;
            m = WMASK;
        end else begin
            m = root_floor(div_sat(mag(u) * mag(u) + mag(v) * mag(v), FRAC, a2, ~64'd0));
            if (m > WMASK)
                m = WMASK;
        end
        r.pressure = p[31:0];
        r.temperature = t[31:0];
        r.mach = m[31:0];
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            stall_left <= 400;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left <= gap_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'({m_tuser, m_tdata});
            if (primitive_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatch_cnt++;
            end else begin
                want = primitive_q.pop_front();
                if (got.density_out !== want.density_out) begin
                    $error("density_out exp %h got %h", want.density_out, got.density_out);
                    mismatch_cnt++;
                end
                if (got.velocity_x !== want.velocity_x) begin
                    $error("velocity_x exp %h got %h", want.velocity_x, got.velocity_x);
                    mismatch_cnt++;
                end
                if (got.velocity_y !== want.velocity_y) begin
                    $error("velocity_y exp %h got %h", want.velocity_y, got.velocity_y);
                    mismatch_cnt++;
                end
                if (got.pressure !== want.pressure) begin
                    $error("pressure exp %h got %h", want.pressure, got.pressure);
                    mismatch_cnt++;
                end
                if (got.temperature !== want.temperature) begin
                    $error("temperature exp %h got %h", want.temperature, got.temperature);
                    mismatch_cnt++;
                end
                if (got.mach !== want.mach) begin
                    $error("mach exp %h got %h", want.mach, got.mach);
                    mismatch_cnt++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic send_cell(logic [31:0] rho, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] en);
        int g;
        g = gaps_on ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {en, my, mx, rho};
        do @(posedge aclk); while (!s_tready);
        primitive_q.push_back(primitive_of(rho, mx, my, en));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (primitive_q.size() == 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_GAMMA)
            gamma_cfg = data[GAMMA_W-1:0];
        else
            gas_cfg = data;
    endtask

    task automatic send_random_cell();
        longint signed rho;
        longint signed mx;
        longint signed my;
        longint signed ke;
        longint signed en;
        if ($urandom_range(0, 99) < 20) begin
            send_cell($urandom, $urandom, $urandom, $urandom);
        end else begin
            rho = $urandom_range(1, 1 << $urandom_range(4, 30));
            mx = sat_s32((rho * (longint'($urandom) - 64'sd2147483648)) >>> $urandom_range(16, 30));
            my = sat_s32((rho * (longint'($urandom) - 64'sd2147483648)) >>> $urandom_range(16, 30));
            ke = (mx * mx + my * my) / (2 * rho);
            if ($urandom_range(0, 9) == 0)
                en = ke - $urandom_range(0, 1 << 16);
            else
                en = ke + $urandom_range(0, 1 << $urandom_range(0, 31));
            en = sat_s32(en);
            send_cell(rho[31:0], mx[31:0], my[31:0], en[31:0]);
        end
    endtask

    task automatic test_directed();
        send_cell(32'd0, 32'd100, 32'd100, 32'd100);
        send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cell(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_cell(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cell(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h8000_0000);
        send_cell(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_cell(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0010_0000);
        send_cell(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0004_0000);
        send_cell(32'h0001_0000, 32'h0100_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_cell(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_cell(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_cell(32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        drain();
    endtask

    task automatic test_register_sweep();
        logic [31:0] gammas[6];
        logic [31:0] gases[6];
        gammas = '{32'd65536, 32'd262144, 32'd0, 32'h7FFFF, 32'd32768, 32'd91750};
        gases = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd18808832, 32'd65536, 32'd18808832};
        for (int k = 0; k < 6; k++) begin
            write_reg(ADDR_GAMMA, gammas[k]);
            write_reg(ADDR_GAS, gases[k]);
            for (int n = 0; n < 40; n++)
                send_random_cell();
            send_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0010_0000);
            drain();
        end
    endtask

    task automatic test_random_stream();
        for (int k = 0; k < 8; k++) begin
            gaps_on = (k % 3) != 2;
            stalls_on = (k % 4) != 3;
            write_reg(ADDR_GAMMA, $urandom_range(65536, 262144));
            write_reg(ADDR_GAS, $urandom_range(1, 32'h1000_0000));
            for (int n = 0; n < 85; n++)
                send_random_cell();
            drain();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(ADDR_GAMMA, 32'd91750);
        write_reg(ADDR_GAS, 32'd18808832);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        for (int n = 0; n < 300; n++)
            send_random_cell();
        drain();
        for (int n = 0; n < 20; n++)
            send_random_cell();
        drain();
        gaps_on = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gamma_cfg = GAMMA_RESET;
        gas_cfg = GAS_RESET;
        mismatch_cnt = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_sweep();
        test_random_stream();
        test_backpressure();
        repeat (250) @(posedge aclk);
        if (mismatch_cnt == 0 && primitive_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
